/* hw/rtl/frustum_box_point_cull_assert.svh */
// Assertion macros shared by the frustum cull RTL.
// Relies on clk and rst_n being visible in the including module.
`ifndef FRUSTUM_BOX_POINT_CULL_ASSERT_SVH
`define FRUSTUM_BOX_POINT_CULL_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FBPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpc assertion failed");

// Next-cycle implication, disabled in reset.
`define FBPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpc assertion failed");

`endif

/* hw/rtl/fbpc_pkg.sv */
// Package for the frustum cull block: codes, widths, chain token and helpers.
// No dependencies.
`timescale 1ns / 1ps

package fbpc_pkg;

    localparam int PLANE_COUNT_DEF = 6;
    localparam int IDX_W           = 3;
    localparam int NRM_W           = 16;
    localparam int CRD_W           = 32;
    localparam int EXT_W           = 31;
    localparam int PROD_W          = 48;
    localparam int DIST_W          = 53;
    localparam int OFF_SHIFT       = 14;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_BOX   = 2'd1,
        MODE_POINT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        VIS_OUTSIDE = 2'd0,
        VIS_PARTIAL = 2'd1,
        VIS_INSIDE  = 2'd2
    } vis_t;

    // One beat as it travels down the cell chain.
    typedef struct packed {
        logic                    valid;
        logic [1:0]              mode;
        logic [IDX_W-1:0]        plane_index;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic signed [CRD_W-1:0] offset;
        logic signed [CRD_W-1:0] center_x;
        logic signed [CRD_W-1:0] center_y;
        logic signed [CRD_W-1:0] center_z;
        logic [EXT_W-1:0]        extent_x;
        logic [EXT_W-1:0]        extent_y;
        logic [EXT_W-1:0]        extent_z;
        vis_t                    vis;
    } token_t;

    // |n| of a Q2.14 value; -32768 maps to 32768 exactly.
    function automatic logic [NRM_W:0] abs_normal(input logic signed [NRM_W-1:0] n);
        logic signed [NRM_W:0] w;
        w = {n[NRM_W-1], n};
        return n[NRM_W-1] ? (NRM_W+1)'(-w) : (NRM_W+1)'(w);
    endfunction

endpackage

/* hw/rtl/fbpc_item_if.sv */
// Input channel: valid/ready plus one plane write or test beat.
// Depends on fbpc_pkg.
`timescale 1ns / 1ps

interface fbpc_item_if;
    import fbpc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [IDX_W-1:0]        plane_index;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic signed [CRD_W-1:0] offset;
    logic signed [CRD_W-1:0] center_x;
    logic signed [CRD_W-1:0] center_y;
    logic signed [CRD_W-1:0] center_z;
    logic [EXT_W-1:0]        extent_x;
    logic [EXT_W-1:0]        extent_y;
    logic [EXT_W-1:0]        extent_z;

    modport source (
        output valid, mode, plane_index, normal_x, normal_y, normal_z, offset,
               center_x, center_y, center_z, extent_x, extent_y, extent_z,
        input  ready
    );

    modport sink (
        input  valid, mode, plane_index, normal_x, normal_y, normal_z, offset,
               center_x, center_y, center_z, extent_x, extent_y, extent_z,
        output ready
    );
endinterface

/* hw/rtl/fbpc_result_if.sv */
// Result channel: valid/ready plus the visibility code.
// No dependencies.
`timescale 1ns / 1ps

interface fbpc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] visibility;

    modport source (output valid, visibility, input ready);
    modport sink (input valid, visibility, output ready);
endinterface

/* hw/rtl/fbpc_cell.sv */
// One chain cell: holds one plane, tests each passing beat against it in
// three stages (products, sums, compare). Depends on fbpc_pkg.
`timescale 1ns / 1ps

module fbpc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  fbpc_pkg::token_t tok_in,
    output fbpc_pkg::token_t tok_out
);
    import fbpc_pkg::*;

`include "frustum_box_point_cull_assert.svh"

    // plane storage
    logic signed [NRM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [CRD_W-1:0] off_reg;
    logic                    wr_hit;

    // stage 1: products
    token_t                   tok1_reg;
    logic signed [PROD_W-1:0] pc_reg [3];
    logic [PROD_W-1:0]        pe_reg [3];
    logic signed [CRD_W-1:0]  off1_reg;
    logic signed [PROD_W-1:0] pc_next [3];
    logic [PROD_W-1:0]        pe_next [3];

    // stage 2: distances
    token_t                   tok2_reg;
    logic signed [DIST_W-1:0] cd_reg, cd_next;
    logic [DIST_W-1:0]        ed_reg, ed_next;

    // stage 3: verdict
    token_t                   tok3_reg, tok3_next;
    logic signed [DIST_W-1:0] near_w, far_w;

    assign wr_hit = adv && tok_in.valid && (tok_in.mode == MODE_WRITE)
                    && (tok_in.plane_index == IDX_W'(CELL_INDEX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= '0;
            off_reg <= '0;
        end
        else if (wr_hit)
        begin
            nx_reg  <= tok_in.normal_x;
            ny_reg  <= tok_in.normal_y;
            nz_reg  <= tok_in.normal_z;
            off_reg <= tok_in.offset;
        end
    end

    always_comb
    begin
        pc_next[0] = PROD_W'(nx_reg) * PROD_W'(tok_in.center_x);
        pc_next[1] = PROD_W'(ny_reg) * PROD_W'(tok_in.center_y);
        pc_next[2] = PROD_W'(nz_reg) * PROD_W'(tok_in.center_z);
        pe_next[0] = PROD_W'(abs_normal(nx_reg)) * PROD_W'(tok_in.extent_x);
        pe_next[1] = PROD_W'(abs_normal(ny_reg)) * PROD_W'(tok_in.extent_y);
        pe_next[2] = PROD_W'(abs_normal(nz_reg)) * PROD_W'(tok_in.extent_z);
    end

    always_comb
    begin
        cd_next = DIST_W'(pc_reg[0]) + DIST_W'(pc_reg[1]) + DIST_W'(pc_reg[2])
                  + (DIST_W'(off1_reg) <<< OFF_SHIFT);
        ed_next = DIST_W'(pe_reg[0]) + DIST_W'(pe_reg[1]) + DIST_W'(pe_reg[2]);
    end

    assign far_w  = cd_reg + $signed(ed_reg);
    assign near_w = cd_reg - $signed(ed_reg);

    // outside is sticky; partial only downgrades inside
    always_comb
    begin
        tok3_next = tok2_reg;
        case (tok2_reg.mode)
            MODE_BOX:
            begin
                if (far_w < 0)
                    tok3_next.vis = VIS_OUTSIDE;
                else if ((near_w < 0) && (tok2_reg.vis == VIS_INSIDE))
                    tok3_next.vis = VIS_PARTIAL;
            end
            MODE_POINT:
            begin
                if (cd_reg <= 0)
                    tok3_next.vis = VIS_OUTSIDE;
            end
            default:
            begin
                tok3_next.vis = tok2_reg.vis;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg <= '0;
            tok2_reg <= '0;
            tok3_reg <= '0;
        end
        else if (adv)
        begin
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
            tok3_reg <= tok3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pc_reg   <= pc_next;
            pe_reg   <= pe_next;
            off1_reg <= off_reg;
            cd_reg   <= cd_next;
            ed_reg   <= ed_next;
        end
    end

    assign tok_out = tok3_reg;

    `FBPC_ASSERT_NEXT(a_outside_sticky, adv && tok2_reg.valid && (tok2_reg.vis == VIS_OUTSIDE), tok3_reg.vis == VIS_OUTSIDE)
    `FBPC_ASSERT_NOW(a_point_not_partial, tok3_reg.valid && (tok3_reg.mode == MODE_POINT), tok3_reg.vis != VIS_PARTIAL)
    `FBPC_ASSERT_NEXT(a_frozen_holds, !adv, $stable(tok3_reg) && $stable(nx_reg) && $stable(off_reg))

endmodule

/* hw/rtl/frustum_box_point_cull.sv */
// Frustum cull of boxes and points against a table of clipping planes.
// Depends on fbpc_pkg, fbpc_item_if, fbpc_result_if, fbpc_cell.
//
// Usage:
//   item   : input beats. mode MODE_WRITE loads plane plane_index (normal,
//            offset) and gives no result; MODE_BOX tests center/extent;
//            MODE_POINT tests center. Mode 3 and writes to an index at or
//            beyond PLANE_COUNT are taken and dropped.
//   result : one visibility beat per box or point test, in input order.
// Pipeline: three stages per plane cell (products, sums, compare); a test
//   passes every cell between item accept and result valid.
// Throughput: one beat per cycle while the result side takes beats; the
//   chain of plane cells is a single pipeline that advances as a whole.
// Stall: when a result sits unread, the whole chain freezes and item.ready
//   drops in the same cycle; nothing is lost or repeated.
// Reset: all planes clear to zero (boxes then read inside, points
//   outside) and the chain empties; no warm-up pass is needed.
`timescale 1ns / 1ps

module frustum_box_point_cull #(
    parameter int PLANE_COUNT = fbpc_pkg::PLANE_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    fbpc_item_if.sink     item,
    fbpc_result_if.source result
);
    import fbpc_pkg::*;

`include "frustum_box_point_cull_assert.svh"

    // chain[0] is the entry beat, chain[PLANE_COUNT] the output register
    token_t chain [PLANE_COUNT+1];
    token_t last;
    logic   adv;
    logic   last_is_test;

    assign last         = chain[PLANE_COUNT];
    assign last_is_test = last.mode inside {MODE_BOX, MODE_POINT};

    // The chain moves unless a result is waiting and not taken.
    assign adv        = !(last.valid && last_is_test && !result.ready);
    assign item.ready = adv;

    always_comb
    begin
        chain[0].valid       = item.valid && (item.mode inside {MODE_WRITE, MODE_BOX, MODE_POINT});
        chain[0].mode        = item.mode;
        chain[0].plane_index = item.plane_index;
        chain[0].normal_x    = item.normal_x;
        chain[0].normal_y    = item.normal_y;
        chain[0].normal_z    = item.normal_z;
        chain[0].offset      = item.offset;
        chain[0].center_x    = item.center_x;
        chain[0].center_y    = item.center_y;
        chain[0].center_z    = item.center_z;
        chain[0].extent_x    = item.extent_x;
        chain[0].extent_y    = item.extent_y;
        chain[0].extent_z    = item.extent_z;
        chain[0].vis         = VIS_INSIDE;
    end

    // A plane write travels the chain like a test, so every test sees
    // exactly the writes accepted before it.
    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_cell
        fbpc_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    assign result.valid      = last.valid && last_is_test;
    assign result.visibility = last.vis;

    `FBPC_ASSERT_NOW(a_stall_blocks_input, result.valid && !result.ready, !item.ready)
    `FBPC_ASSERT_NOW(a_point_result, result.valid && (last.mode == MODE_POINT), result.visibility != VIS_PARTIAL)
    `FBPC_ASSERT_NOW(a_result_after_advance, $rose(result.valid), $past(item.ready))

endmodule
